FILE: rtl/core/dtet_pkg.sv
package dtet_pkg;

	// Kinds of result item
	typedef enum logic [1:0] {
		RES_ADD_ACK   = 2'd0,
		RES_FIRED     = 2'd1,
		RES_SCAN_DONE = 2'd2
	} res_kind_t;

	// Kinds of stored entry
	typedef enum logic [1:0] {
		ENT_DETECTOR = 2'd0,
		ENT_TIMED    = 2'd1,
		ENT_DELAYED  = 2'd2
	} ent_kind_t;

	localparam logic ADD_STORED   = 1'b0;
	localparam logic ADD_REJECTED = 1'b1;

	typedef struct packed {
		logic        cmd;
		logic        is_timed;
		logic [3:0]  detector_index;
		logic        trigger_level;
		logic [15:0] duration_ms;
		logic [7:0]  target_id;
		logic [15:0] event_code;
		logic        one_shot;
		logic [31:0] now_ms;
		logic [15:0] detector_levels;
	} dtet_in_t;

	typedef struct packed {
		logic [1:0]  kind;
		logic        status;
		logic [7:0]  fired_target;
		logic [15:0] fired_code;
		logic        last;
	} dtet_out_t;

	typedef struct packed {
		ent_kind_t   kind;
		logic [3:0]  detector;
		logic        trigger;
		logic [15:0] duration;
		logic [31:0] start;
		logic [7:0]  target;
		logic [15:0] code;
		logic        one_shot;
	} dtet_entry_t;

	// Controller to datapath
	typedef struct packed {
		logic      take_in;
		logic      add_store;
		logic      rd_issue;
		logic      ev_step;
		logic      scan_end;
		logic      out_load;
		res_kind_t kind;
	} dtet_cmd_t;

	// Datapath to controller
	typedef struct packed {
		logic new_is_scan;
		logic rd_at_end;
		logic ev_fire;
		logic out_free;
	} dtet_sts_t;

endpackage

FILE: rtl/core/detector_and_timer_event_table_unit.sv
// Event table of up to TABLE_DEPTH pending entries in insertion order. An add
// transaction is accepted, then stored and acknowledged when the output
// register is free. In a scan transaction each entry is read from the
// single-port entry memory (registered read), then evaluated and written
// back compacted; an entry that fires waits until the output register is free.
// One transaction is worked on at a time; a finished result waits in the
// output register while the next input transaction is accepted. Detector
// lines at or above DETECTOR_COUNT read as level 0.
module detector_and_timer_event_table_unit #(
	parameter int TABLE_DEPTH    = 16,
	parameter int DETECTOR_COUNT = 16
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_stall,
	input  dtet_pkg::dtet_in_t  in_data,
	output logic                out_valid,
	input  logic                out_stall,
	output dtet_pkg::dtet_out_t out_data
);
	import dtet_pkg::*;

	dtet_cmd_t cmd;
	dtet_sts_t sts;

	dtet_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.sts      (sts),
		.cmd      (cmd)
	);

	dtet_dp #(
		.TABLE_DEPTH    (TABLE_DEPTH),
		.DETECTOR_COUNT (DETECTOR_COUNT)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_data   (in_data),
		.cmd       (cmd),
		.sts       (sts),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data)
	);

endmodule

FILE: rtl/core/dtet_ctrl.sv
module dtet_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_stall,
	input  dtet_pkg::dtet_sts_t sts,
	output dtet_pkg::dtet_cmd_t cmd
);
	import dtet_pkg::*;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_ADD,
		ST_SCAN_RD,
		ST_SCAN_EV,
		ST_SCAN_END
	} state_t;

	state_t state_q;
	state_t state_nx;

	assign in_stall = (state_q != ST_IDLE);

	always_comb begin
		state_nx = state_q;
		cmd = '0;
		cmd.kind = RES_ADD_ACK;
		case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					cmd.take_in = 1'b1;
					state_nx = sts.new_is_scan ? ST_SCAN_RD : ST_ADD;
				end
			end
			ST_ADD: begin
				if (sts.out_free) begin
					cmd.add_store = 1'b1;
					cmd.out_load = 1'b1;
					cmd.kind = RES_ADD_ACK;
					state_nx = ST_IDLE;
				end
			end
			ST_SCAN_RD: begin
				if (sts.rd_at_end) begin
					state_nx = ST_SCAN_END;
				end else begin
					cmd.rd_issue = 1'b1;
					state_nx = ST_SCAN_EV;
				end
			end
			ST_SCAN_EV: begin
				// hold the entry until its fired transaction has room
				if (!sts.ev_fire || sts.out_free) begin
					cmd.ev_step = 1'b1;
					cmd.out_load = sts.ev_fire;
					cmd.kind = RES_FIRED;
					state_nx = ST_SCAN_RD;
				end
			end
			ST_SCAN_END: begin
				if (sts.out_free) begin
					cmd.scan_end = 1'b1;
					cmd.out_load = 1'b1;
					cmd.kind = RES_SCAN_DONE;
					state_nx = ST_IDLE;
				end
			end
			default: begin
				state_nx = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_nx;
		end
	end

endmodule

FILE: rtl/core/dtet_dp.sv
module dtet_dp #(
	parameter int TABLE_DEPTH    = 16,
	parameter int DETECTOR_COUNT = 16
) (
	input  logic                clk,
	input  logic                arst_n,
	input  dtet_pkg::dtet_in_t  in_data,
	input  dtet_pkg::dtet_cmd_t cmd,
	output dtet_pkg::dtet_sts_t sts,
	output logic                out_valid,
	input  logic                out_stall,
	output dtet_pkg::dtet_out_t out_data
);
	import dtet_pkg::*;

	localparam int CW = $clog2(TABLE_DEPTH + 1);
	localparam int IW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;

	dtet_in_t    in_q;
	logic [CW-1:0] count_q;
	logic [CW-1:0] rd_q;
	logic [CW-1:0] wr_q;

	dtet_entry_t mem_q [TABLE_DEPTH];
	dtet_entry_t rd_data_q;

	logic        mem_we;
	logic [IW-1:0] mem_wa;
	dtet_entry_t mem_wd;
	dtet_entry_t add_ent;

	dtet_entry_t upd;
	logic        fire;
	logic        keep;
	logic        lvl;
	logic [32:0] due;

	logic        out_valid_q;
	dtet_out_t   out_q;
	logic        table_full;

	assign table_full = (count_q == CW'(TABLE_DEPTH));

	// Evaluate the entry that was read last
	always_comb begin
		upd = rd_data_q;
		fire = 1'b0;
		lvl = 1'b0;
		due = {1'b0, rd_data_q.start} + {17'd0, rd_data_q.duration};
		if (int'(rd_data_q.detector) < DETECTOR_COUNT) begin
			lvl = in_q.detector_levels[rd_data_q.detector];
		end
		if (rd_data_q.kind == ENT_DETECTOR) begin
			if (lvl == rd_data_q.trigger) begin
				if (rd_data_q.duration != 16'd0) begin
					upd.kind = ENT_DELAYED;
					upd.start = in_q.now_ms;
				end else begin
					fire = 1'b1;
				end
			end
		end else begin
			if (due <= {1'b0, in_q.now_ms}) begin
				fire = 1'b1;
				if (rd_data_q.kind == ENT_DELAYED) begin
					upd.kind = ENT_DETECTOR;
				end
			end
		end
		keep = !(fire && rd_data_q.one_shot);
		if (fire && rd_data_q.kind == ENT_TIMED) begin
			upd.start = in_q.now_ms;
		end
	end

	always_comb begin
		add_ent.kind = in_q.is_timed ? ENT_TIMED : ENT_DETECTOR;
		add_ent.detector = in_q.detector_index;
		add_ent.trigger = in_q.trigger_level;
		add_ent.duration = in_q.duration_ms;
		add_ent.start = in_q.is_timed ? in_q.now_ms : 32'd0;
		add_ent.target = in_q.target_id;
		add_ent.code = in_q.event_code;
		add_ent.one_shot = in_q.one_shot;
	end

	always_comb begin
		mem_we = 1'b0;
		mem_wa = wr_q[IW-1:0];
		mem_wd = upd;
		if (cmd.add_store && !table_full) begin
			mem_we = 1'b1;
			mem_wa = count_q[IW-1:0];
			mem_wd = add_ent;
		end else if (cmd.ev_step && keep) begin
			mem_we = 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem_q[mem_wa] <= mem_wd;
		end
		if (cmd.rd_issue) begin
			rd_data_q <= mem_q[rd_q[IW-1:0]];
		end
		if (cmd.take_in) begin
			in_q <= in_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			rd_q <= '0;
			wr_q <= '0;
		end else begin
			if (cmd.take_in) begin
				rd_q <= '0;
				wr_q <= '0;
			end
			if (cmd.add_store && !table_full) begin
				count_q <= count_q + CW'(1);
			end
			if (cmd.ev_step) begin
				rd_q <= rd_q + CW'(1);
				if (keep) begin
					wr_q <= wr_q + CW'(1);
				end
			end
			// drop the removed entries from the tail
			if (cmd.scan_end) begin
				count_q <= wr_q;
			end
		end
	end

	assign sts.new_is_scan = in_data.cmd;
	assign sts.rd_at_end = (rd_q == count_q);
	assign sts.ev_fire = fire;
	assign sts.out_free = !out_valid_q || !out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.out_load) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			out_q.kind <= cmd.kind;
			out_q.status <= (cmd.kind == RES_ADD_ACK && table_full) ? ADD_REJECTED : ADD_STORED;
			out_q.fired_target <= (cmd.kind == RES_FIRED) ? rd_data_q.target : 8'd0;
			out_q.fired_code <= (cmd.kind == RES_FIRED) ? rd_data_q.code : 16'd0;
			out_q.last <= (cmd.kind != RES_FIRED);
		end
	end

	assign out_valid = out_valid_q;
	assign out_data = out_q;

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(TABLE_DEPTH))
		else $error("entry count exceeds table depth");

	a_wr_behind_rd: assert property (@(posedge clk) disable iff (!arst_n)
		wr_q <= rd_q)
		else $error("compaction write pointer passed read pointer");

	a_load_when_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |-> sts.out_free)
		else $error("result loaded over a waiting transaction");

	a_full_reject: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.add_store && table_full |=> $stable(count_q))
		else $error("full table took an entry");

endmodule

FILE: tb/sv/event_table_checker.sv
`timescale 1ns / 100ps

module event_table_checker #(
	parameter int TABLE_DEPTH    = 16,
	parameter int DETECTOR_COUNT = 16
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	input  logic                in_stall,
	input  dtet_pkg::dtet_in_t  in_data,
	input  logic                out_valid,
	input  logic                out_stall,
	input  dtet_pkg::dtet_out_t out_data,
	output int                  fault_count,
	output int                  outstanding
);
	import dtet_pkg::*;

	dtet_entry_t slots [TABLE_DEPTH];
	int          slots_used;
	dtet_out_t   awaited_results [$];
	dtet_out_t   oldest;

	function automatic void await_result(res_kind_t k, logic st, logic [7:0] tgt,
			logic [15:0] code, logic fin);
		dtet_out_t r;
		r.kind         = k;
		r.status       = st;
		r.fired_target = tgt;
		r.fired_code   = code;
		r.last         = fin;
		awaited_results.push_back(r);
	endfunction

	// Update the local copy of the table and queue the results one transaction causes
	function automatic void evaluate_item(dtet_in_t t);
		dtet_entry_t e;
		logic        level;
		logic        fired;
		logic [32:0] due;
		int          keep;
		if (t.cmd == 1'b0) begin
			if (slots_used >= TABLE_DEPTH) begin
				await_result(RES_ADD_ACK, ADD_REJECTED, 8'h00, 16'h0000, 1'b1);
				return;
			end
			e.kind     = t.is_timed ? ENT_TIMED : ENT_DETECTOR;
			e.detector = t.detector_index;
			e.trigger  = t.trigger_level;
			e.duration = t.duration_ms;
			e.start    = t.is_timed ? t.now_ms : 32'd0;
			e.target   = t.target_id;
			e.code     = t.event_code;
			e.one_shot = t.one_shot;
			slots[slots_used] = e;
			slots_used++;
			await_result(RES_ADD_ACK, ADD_STORED, 8'h00, 16'h0000, 1'b1);
			return;
		end
		keep = 0;
		for (int i = 0; i < slots_used; i++) begin
			e     = slots[i];
			fired = 1'b0;
			if (e.kind == ENT_DETECTOR) begin
				level = (int'(e.detector) < DETECTOR_COUNT) ?
					t.detector_levels[e.detector] : 1'b0;
				if (level == e.trigger) begin
					// arm the delay instead of firing
					if (e.duration != 16'd0) begin
						e.kind  = ENT_DELAYED;
						e.start = t.now_ms;
					end else begin
						fired = 1'b1;
					end
				end
			end else begin
				due = {1'b0, e.start} + {17'b0, e.duration};
				if (due <= {1'b0, t.now_ms}) begin
					if (e.kind == ENT_DELAYED)
						e.kind = ENT_DETECTOR;
					fired = 1'b1;
				end
			end
			if (fired)
				await_result(RES_FIRED, 1'b0, e.target, e.code, 1'b0);
			if (!(fired && e.one_shot)) begin
				if (fired && e.kind == ENT_TIMED)
					e.start = t.now_ms;
				slots[keep] = e;
				keep++;
			end
		end
		slots_used = keep;
		await_result(RES_SCAN_DONE, 1'b0, 8'h00, 16'h0000, 1'b1);
	endfunction

	task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
		if (got !== want) begin
			$error("%s: expected 0x%0h, got 0x%0h", name, want, got);
			fault_count++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slots_used = 0;
			awaited_results.delete();
			fault_count = 0;
			outstanding <= 0;
		end else begin
			// compare results before predicting, a new transaction cannot answer at its own edge
			if (out_valid && !out_stall) begin
				if (awaited_results.size() == 0) begin
					$error("kind: expected no result, got %0d", out_data.kind);
					fault_count++;
				end else begin
					oldest = awaited_results.pop_front();
					check_field("kind", 32'(oldest.kind), 32'(out_data.kind));
					check_field("status", 32'(oldest.status), 32'(out_data.status));
					check_field("fired_target", 32'(oldest.fired_target),
						32'(out_data.fired_target));
					check_field("fired_code", 32'(oldest.fired_code),
						32'(out_data.fired_code));
					check_field("last", 32'(oldest.last), 32'(out_data.last));
				end
			end
			if (in_valid && !in_stall)
				evaluate_item(in_data);
			outstanding <= awaited_results.size();
		end
	end

endmodule

FILE: tb/sv/detector_and_timer_event_table_unit_test.sv
`timescale 1ns / 100ps

module detector_and_timer_event_table_unit_test;
	import dtet_pkg::*;

	localparam int TABLE_DEPTH    = 16;
	localparam int DETECTOR_COUNT = 16;
	localparam int RANDOM_ITEMS   = 130;
	localparam int QUIET_ITEMS    = 30;
	localparam int CYCLE_LIMIT    = 400000;
	localparam int TAIL_CYCLES    = 60;

	logic      clk = 1'b0;
	logic      arst_n;
	logic      in_valid;
	logic      in_stall;
	dtet_in_t  in_data;
	logic      out_valid;
	logic      out_stall;
	dtet_out_t out_data;
	int        fault_count;
	int        outstanding;
	int        cycle_count;
	logic      quiet = 1'b0;

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	detector_and_timer_event_table_unit #(
		.TABLE_DEPTH    (TABLE_DEPTH),
		.DETECTOR_COUNT (DETECTOR_COUNT)
	) DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data)
	);

	event_table_checker #(
		.TABLE_DEPTH    (TABLE_DEPTH),
		.DETECTOR_COUNT (DETECTOR_COUNT)
	) CHECK (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.in_data     (in_data),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.out_data    (out_data),
		.fault_count (fault_count),
		.outstanding (outstanding)
	);

	function automatic dtet_in_t add_item(logic timed, logic [3:0] line, logic trig,
			logic [15:0] dur, logic [7:0] tgt, logic [15:0] code, logic once,
			logic [31:0] now);
		dtet_in_t t;
		t.cmd             = 1'b0;
		t.is_timed        = timed;
		t.detector_index  = line;
		t.trigger_level   = trig;
		t.duration_ms     = dur;
		t.target_id       = tgt;
		t.event_code      = code;
		t.one_shot        = once;
		t.now_ms          = now;
		t.detector_levels = 16'($urandom);
		return t;
	endfunction

	// add fields ride along at random, the block ignores them on a scan
	function automatic dtet_in_t scan_item(logic [31:0] now, logic [15:0] levels);
		dtet_in_t t;
		t                 = add_item(1'($urandom), 4'($urandom), 1'($urandom),
			16'($urandom), 8'($urandom), 16'($urandom), 1'($urandom), now);
		t.cmd             = 1'b1;
		t.detector_levels = levels;
		return t;
	endfunction

	task automatic send(input dtet_in_t t);
		if (!quiet && $urandom_range(0, 5) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 15)) @(posedge clk);
		end
		in_valid <= 1'b1;
		in_data  <= t;
		@(posedge clk);
		while (in_stall) @(posedge clk);
	endtask

	// hold off the sender until every awaited result has come back
	task automatic drain();
		in_valid <= 1'b0;
		@(posedge clk);
		while (outstanding != 0) @(posedge clk);
	endtask

	// receiver stall bursts
	initial begin
		out_stall <= 1'b0;
		forever begin
			@(posedge clk);
			if (!quiet && $urandom_range(0, 7) == 0) begin
				out_stall <= 1'b1;
				repeat ($urandom_range(1, 15)) @(posedge clk);
				out_stall <= 1'b0;
			end
		end
	end

	initial begin
		cycle_count = 0;
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("DONE: errors detected");
		$finish;
	end

	initial begin
		logic [31:0]  clock_ms;
		logic [127:0] noise_bits;
		logic [15:0]  dur;
		int           pick;
		arst_n   <= 1'b0;
		in_valid <= 1'b0;
		in_data  <= '0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// scan of an empty table, then one entry of each flavor at the field extremes
		send(scan_item(32'd0, 16'h0000));
		send(add_item(1'b0, 4'd0, 1'b1, 16'd0, 8'hFF, 16'hFFFF, 1'b1, 32'hFFFF_FFFF));
		send(add_item(1'b0, 4'd15, 1'b0, 16'd0, 8'h00, 16'h0000, 1'b0, 32'd0));
		send(add_item(1'b1, 4'd3, 1'b1, 16'd0, 8'h5A, 16'h1234, 1'b0, 32'd50));
		send(add_item(1'b1, 4'd9, 1'b0, 16'hFFFF, 8'hA5, 16'h8001, 1'b1, 32'd1000));
		send(add_item(1'b0, 4'd7, 1'b1, 16'd100, 8'h3C, 16'h7FFE, 1'b1, 32'd0));
		// due time passes the top of the 32-bit range, never fires
		send(add_item(1'b1, 4'd12, 1'b0, 16'h0020, 8'hC3, 16'h4321, 1'b1, 32'hFFFF_FFF0));
		send(scan_item(32'd100, 16'h0001));
		send(scan_item(32'd200, 16'h0080));
		send(scan_item(32'd299, 16'h0000));
		send(scan_item(32'd300, 16'h7FFF));
		send(scan_item(32'h0001_03E7, 16'h8000));
		send(scan_item(32'hFFFF_FFFF, 16'hFFFF));
		drain();

		// fill the table past full, then fire nearly every entry in one scan
		repeat (14)
			send(add_item(1'b1, 4'($urandom), 1'($urandom), 16'd0, 8'($urandom),
				16'($urandom), 1'b1, 32'h0001_0000));
		send(scan_item(32'h0002_0000, 16'h0000));

		clock_ms = $urandom_range(0, 1 << 20);
		for (int n = 0; n < RANDOM_ITEMS; n++) begin
			if (n == RANDOM_ITEMS / 2)
				drain();
			// move near the wrap of the time counter late in the run
			if (n == RANDOM_ITEMS - 40)
				clock_ms = 32'hFFFF_F000;
			quiet = (n >= RANDOM_ITEMS - QUIET_ITEMS);
			pick  = $urandom_range(0, 99);
			if (pick < 55) begin
				case ($urandom_range(0, 2))
					0:       dur = 16'd0;
					1:       dur = 16'($urandom_range(1, 200));
					default: dur = 16'($urandom);
				endcase
				send(add_item(1'($urandom), 4'($urandom), 1'($urandom), dur,
					8'($urandom), 16'($urandom), $urandom_range(0, 9) != 0, clock_ms));
			end else if (pick < 90) begin
				if ($urandom_range(0, 9) == 0)
					clock_ms += $urandom_range(0, 70000);
				else
					clock_ms += $urandom_range(0, 150);
				send(scan_item(clock_ms, 16'($urandom)));
			end else begin
				noise_bits = {$urandom, $urandom, $urandom, $urandom};
				send(noise_bits[$bits(dtet_in_t)-1:0]);
			end
		end
		drain();
		repeat (TAIL_CYCLES) @(posedge clk);

		if (fault_count == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule

FILE: detector_and_timer_event_table_unit.f
rtl/core/dtet_pkg.sv
rtl/core/dtet_ctrl.sv
rtl/core/dtet_dp.sv
rtl/core/detector_and_timer_event_table_unit.sv
tb/sv/event_table_checker.sv
tb/sv/detector_and_timer_event_table_unit_test.sv
